>>> hdl/spf_pkg.sv
// Shared types and constants for the serial port with receive and transmit FIFOs.
// Holds the transaction structs, request codes, window offsets and state encoding.
// No dependencies; every other file of the block but spf_ram imports this package.
package spf_pkg;

  // FIFO geometry: a ring of FIFO_DEPTH entries holds FIFO_DEPTH-1 bytes.
  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Status values.
  localparam logic [7:0] ERR_FLAG = 8'h80;
  localparam logic [7:0] CNT_MAX  = 8'hFF;

  // Register window offsets that carry data.
  localparam logic [3:0] WIN_RX_ERR = 4'd0;
  localparam logic [3:0] WIN_RX_CNT = 4'd3;
  localparam logic [3:0] WIN_RX_DAT = 4'd7;
  localparam logic [3:0] WIN_TX_ERR = 4'd8;
  localparam logic [3:0] WIN_TX_CNT = 4'd11;
  localparam logic [3:0] WIN_TX_DAT = 4'd15;

  // Largest bus access in bytes.
  localparam logic [3:0] ACC_MAX = 4'd8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_DISABLE = 1'b0;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_LINE_RX = 2'd2,
    REQ_DRAIN   = 2'd3
  } req_t;

  // One input transaction.
  typedef struct packed {
    req_t       req_type;
    logic [3:0] offset;
    logic [3:0] access_size;
    logic [7:0] write_byte;
    logic [7:0] rx_byte;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [63:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_raise;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

endpackage

>>> hdl/spf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both FIFO stores; no dependencies.
module spf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/spf_ctrl.sv
// Controller state machine: sequences one transaction through fetch and apply.
// Depends on spf_pkg for the state encoding and the command struct.
module spf_ctrl
  import spf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: fetch waits for the registered FIFO head read, then the update is applied.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_FETCH: begin
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/spf_datapath.sv
// Datapath: FIFO pointers and stores, status registers, window read and result.
// Depends on spf_pkg and instantiates spf_ram for both FIFO stores.
module spf_datapath
  import spf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  in_t                   in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output out_t                  out_data
);

  // Captured request.
  in_t req_r;

  // Ring pointers.
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;

  // Status registers.
  logic [7:0] rx_err_r, rx_err_nxt, rx_cnt_r, rx_cnt_nxt, rx_dat_r, rx_dat_nxt;
  logic [7:0] tx_err_r, tx_err_nxt, tx_cnt_r, tx_cnt_nxt, tx_dat_r, tx_dat_nxt;
  logic       irq_armed_r, irq_armed_nxt;
  logic       irq_dis_r;

  // Result registers.
  logic out_valid_r;
  out_t out_r, out_nxt;

  // Store ports.
  logic       rx_we, tx_we;
  logic [7:0] rx_rdata, tx_rdata;

  // Decoded access.
  logic [3:0] size_c;
  logic [4:0] end_w;
  logic       cov_rx_cnt, cov_rx_dat, cov_tx_dat;
  logic       rx_empty, rx_full, tx_empty, tx_full;
  logic [7:0] w_err, w_cnt, w_dat, w_cnt_inc;
  logic [7:0] rx_cnt_inc, tx_cnt_inc;
  logic [63:0] rd_data;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    logic [7:0] r;
    r = (v == CNT_MAX) ? v : v + 8'd1;
    return r;
  endfunction

  // Byte of the register window at a five-bit index; past the window reads zero.
  function automatic logic [7:0] win_byte(
    input logic [4:0] idx,
    input logic [7:0] e, input logic [7:0] c, input logic [7:0] d,
    input logic [7:0] te, input logic [7:0] tc, input logic [7:0] td
  );
    logic [7:0] r;
    r = 8'd0;
    if (idx == {1'b0, WIN_RX_ERR}) r = e;
    if (idx == {1'b0, WIN_RX_CNT}) r = c;
    if (idx == {1'b0, WIN_RX_DAT}) r = d;
    if (idx == {1'b0, WIN_TX_ERR}) r = te;
    if (idx == {1'b0, WIN_TX_CNT}) r = tc;
    if (idx == {1'b0, WIN_TX_DAT}) r = td;
    return r;
  endfunction

  // FIFO stores, read continuously at their heads.
  spf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail_r),
    .wdata (req_r.rx_byte),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  spf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail_r),
    .wdata (req_r.write_byte),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  // Access decode: clamp the size, find which data bytes it covers, flag FIFO empty and full.
  always_comb begin
    size_c     = (req_r.access_size > ACC_MAX) ? ACC_MAX : req_r.access_size;
    end_w      = {1'b0, req_r.offset} + {1'b0, size_c};
    cov_rx_cnt = (size_c != 4'd0) && (req_r.offset <= WIN_RX_CNT)
                 && (end_w > {1'b0, WIN_RX_CNT});
    cov_rx_dat = (size_c != 4'd0) && (req_r.offset <= WIN_RX_DAT)
                 && (end_w > {1'b0, WIN_RX_DAT});
    cov_tx_dat = (size_c != 4'd0) && (end_w > {1'b0, WIN_TX_DAT});
    rx_empty   = (rx_head_r == rx_tail_r);
    rx_full    = (ptr_next(rx_tail_r) == rx_head_r);
    tx_empty   = (tx_head_r == tx_tail_r);
    tx_full    = (ptr_next(tx_tail_r) == tx_head_r);
    rx_cnt_inc = sat_inc(rx_cnt_r);
    tx_cnt_inc = sat_inc(tx_cnt_r);
    w_cnt_inc  = sat_inc(rx_cnt_r);
  end

  // Read window bytes 0, 3 and 7 as this read leaves them.
  always_comb begin
    w_err = rx_err_r;
    w_cnt = rx_cnt_r;
    w_dat = rx_dat_r;
    if (cov_rx_dat && !rx_empty) begin
      w_cnt = w_cnt_inc;
      w_dat = rx_rdata;
      if (w_cnt_inc > 8'd1) begin
        w_err = ERR_FLAG;
      end
    end
  end

  // Assemble read data, the first byte most significant.
  always_comb begin
    logic [4:0] idx;
    logic [2:0] pos;
    rd_data = '0;
    for (int j = 0; j < 8; j++) begin
      idx = {1'b0, req_r.offset} + 5'(j);
      pos = 3'(size_c - 4'(j) - 4'd1);
      if (4'(j) < size_c) begin
        rd_data[{pos, 3'b000} +: 8] = win_byte(idx, w_err, w_cnt, w_dat,
                                               tx_err_r, tx_cnt_r, tx_dat_r);
      end
    end
  end

  // State update for the transaction in apply.
  always_comb begin
    rx_head_nxt   = rx_head_r;
    rx_tail_nxt   = rx_tail_r;
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    rx_err_nxt    = rx_err_r;
    rx_cnt_nxt    = rx_cnt_r;
    rx_dat_nxt    = rx_dat_r;
    tx_err_nxt    = tx_err_r;
    tx_cnt_nxt    = tx_cnt_r;
    tx_dat_nxt    = tx_dat_r;
    irq_armed_nxt = irq_armed_r;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    out_nxt       = '0;
    if (cmd.apply) begin
      case (req_r.req_type)
        REQ_READ: begin
          out_nxt.read_data = rd_data;
          if (cov_rx_dat) begin
            if (!rx_empty) begin
              rx_head_nxt = ptr_next(rx_head_r);
            end
            rx_err_nxt = 8'd0;
            rx_cnt_nxt = 8'd0;
            rx_dat_nxt = 8'd0;
          end
          if (cov_rx_cnt && (w_cnt == 8'd0)) begin
            irq_armed_nxt = 1'b1;
          end
        end
        REQ_WRITE: begin
          if (cov_tx_dat) begin
            if (tx_full) begin
              tx_dat_nxt = req_r.write_byte;
              tx_err_nxt = ERR_FLAG;
              tx_cnt_nxt = tx_cnt_inc;
            end else begin
              tx_we       = 1'b1;
              tx_tail_nxt = ptr_next(tx_tail_r);
              tx_err_nxt  = 8'd0;
              tx_cnt_nxt  = 8'd0;
              tx_dat_nxt  = 8'd0;
            end
          end
        end
        REQ_LINE_RX: begin
          // On overflow the oldest byte moves into the live registers.
          if (rx_full) begin
            rx_dat_nxt  = rx_rdata;
            rx_head_nxt = ptr_next(rx_head_r);
            rx_cnt_nxt  = rx_cnt_inc;
            if (rx_cnt_inc > 8'd1) begin
              rx_err_nxt = ERR_FLAG;
            end
          end
          if (irq_armed_r && !irq_dis_r && rx_empty) begin
            irq_armed_nxt     = 1'b0;
            out_nxt.irq_raise = 1'b1;
          end
          rx_we       = 1'b1;
          rx_tail_nxt = ptr_next(rx_tail_r);
        end
        REQ_DRAIN: begin
          if (!tx_empty) begin
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_byte  = tx_rdata;
            tx_head_nxt      = ptr_next(tx_head_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_err_r    <= '0;
      rx_cnt_r    <= '0;
      rx_dat_r    <= '0;
      tx_err_r    <= '0;
      tx_cnt_r    <= '0;
      tx_dat_r    <= '0;
      irq_armed_r <= 1'b0;
      irq_dis_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      rx_err_r    <= rx_err_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      rx_dat_r    <= rx_dat_nxt;
      tx_err_r    <= tx_err_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      tx_dat_r    <= tx_dat_nxt;
      irq_armed_r <= irq_armed_nxt;
      out_valid_r <= cmd.apply;
      // The interrupt number is routed by the interrupt fabric; only the
      // disable bit changes behavior inside this block.
      if (cfg_we) begin
        case (cfg_index)
          CFG_IRQ_DISABLE: irq_dis_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.apply) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/serial_port_with_fifos.sv
// Top level of the serial port with receive and transmit FIFOs.
// Depends on spf_pkg, spf_ctrl, spf_datapath and spf_ram.
//
// Usage:
//   Input channel: a transaction is taken at a clock edge where start is high
//   and busy is low. in_data carries the request type (bus read, bus write,
//   line byte received, transmitter drain), the window offset and access
//   size, the write byte and the received line byte.
//   Result channel: every transaction yields one result, shown on out_data
//   for exactly one cycle while out_valid is high. The receiver cannot stall.
//   Configuration port: cfg_we writes cfg_data to register cfg_index at once
//   (0: read interrupt disable; 1: read interrupt number, ignored here).
//   Write only while the block is idle.
// Timing: an accepted transaction passes the fetch and apply states and its
//   result strobe is registered from apply; a new transaction can be taken in
//   the cycle the result is shown, not before. The fetch state waits for the
//   registered read of the FIFO stores before the update is applied.
// Reset: rst_n low clears pointers, status registers, the interrupt arm and
//   the configuration; the FIFOs come up empty and the store contents are
//   not cleared.
module serial_port_with_fifos
  import spf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;

  // Sequencer.
  spf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // FIFOs, status registers and result.
  spf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/spf_checker.sv
// Port-level checks for the serial port with FIFOs, bound to the top level.
// Depends on spf_pkg for the result struct.
module spf_checker
  import spf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  // An accepted transaction delivers its result after the fetch and apply states.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // The block stays busy right after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accept");

  // A result appears only when the block is back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Results are single-cycle strobes.
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result without a transmit byte carries a zero transmit byte.
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tx_valid) |-> (out_data.tx_byte == 8'd0))
    else $error("transmit byte set without transmit valid");

endmodule

bind serial_port_with_fifos spf_checker u_spf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> tb/tb.sv
// Self-checking testbench for serial_port_with_fifos: bus reads and writes, line bytes, drains.
// A scoreboard class mirrors the FIFOs, the status window and the interrupt arm.
// Depends on spf_pkg and the serial_port_with_fifos RTL.
module tb;
  import spf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_NUMBER = 1'b1;
  localparam int unsigned IDLE_LIMIT = 5000;

  // Mirror of the port state; predicts one result per accepted transaction.
  class port_scoreboard;
    logic        irq_disable;
    logic [5:0]  irq_number;
    logic [7:0]  rx_store [FIFO_DEPTH];
    logic [7:0]  tx_store [FIFO_DEPTH];
    int          rx_head, rx_tail, tx_head, tx_tail;
    logic [7:0]  rx_err_live, rx_cnt_live, rx_dat_live;
    logic [7:0]  window [8];
    logic [7:0]  tx_err, tx_cnt, tx_dat;
    logic        irq_armed;
    out_t        pending_results [$];
    int          mismatches;

    function new();
      irq_disable = 1'b0;
      irq_number  = '0;
      rx_head = 0; rx_tail = 0; tx_head = 0; tx_tail = 0;
      rx_err_live = '0; rx_cnt_live = '0; rx_dat_live = '0;
      foreach (window[i]) window[i] = '0;
      tx_err = '0; tx_cnt = '0; tx_dat = '0;
      irq_armed = 1'b0;
      mismatches = 0;
    endfunction

    function int next_ptr(int p);
      return (p == FIFO_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function logic [7:0] window_byte(int idx);
      if (idx < 8) return window[idx];
      if (idx == WIN_TX_ERR) return tx_err;
      if (idx == WIN_TX_CNT) return tx_cnt;
      if (idx == WIN_TX_DAT) return tx_dat;
      return 8'h00;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IRQ_DISABLE) irq_disable = val[0];
      else irq_number = val[5:0];
    endfunction

    // Apply one accepted transaction and queue the result it must produce.
    function void note_input(in_t item);
      out_t res;
      int   size, off, last, idx;
      res  = '0;
      off  = item.offset;
      size = (item.access_size > ACC_MAX) ? ACC_MAX : item.access_size;
      last = off + size;
      case (item.req_type)
        REQ_READ: begin
          window[WIN_RX_ERR] = rx_err_live;
          window[WIN_RX_CNT] = rx_cnt_live;
          window[WIN_RX_DAT] = rx_dat_live;
          // Covering the data byte pops one character, if any, and clears the live status.
          if (size != 0 && off <= WIN_RX_DAT && last > WIN_RX_DAT) begin
            if (rx_head != rx_tail) begin
              if (window[WIN_RX_CNT] < CNT_MAX) window[WIN_RX_CNT]++;
              if (window[WIN_RX_CNT] > 1) window[WIN_RX_ERR] = ERR_FLAG;
              window[WIN_RX_DAT] = rx_store[rx_head];
              rx_head = next_ptr(rx_head);
            end
            rx_err_live = '0;
            rx_cnt_live = '0;
            rx_dat_live = '0;
          end
          // Reading a zero count arms the read interrupt.
          if (size != 0 && off <= WIN_RX_CNT && last > WIN_RX_CNT && window[WIN_RX_CNT] == 0)
            irq_armed = 1'b1;
          for (int i = 0; i < size; i++) begin
            idx = off + i;
            res.read_data = {res.read_data[55:0], (idx < 16) ? window_byte(idx) : 8'h00};
          end
        end
        REQ_WRITE: begin
          if (size != 0 && last > WIN_TX_DAT) begin
            tx_dat = item.write_byte;
            if (next_ptr(tx_tail) == tx_head) begin
              tx_err = ERR_FLAG;
              if (tx_cnt < CNT_MAX) tx_cnt++;
            end else begin
              tx_err = '0;
              tx_store[tx_tail] = tx_dat;
              tx_tail = next_ptr(tx_tail);
              tx_cnt = '0;
              tx_dat = '0;
            end
          end
        end
        REQ_LINE_RX: begin
          // A full receive FIFO drops its oldest byte into the live registers.
          if (next_ptr(rx_tail) == rx_head) begin
            rx_dat_live = rx_store[rx_head];
            rx_head = next_ptr(rx_head);
            if (rx_cnt_live < CNT_MAX) rx_cnt_live++;
            if (rx_cnt_live > 1) rx_err_live = ERR_FLAG;
          end
          if (irq_armed && !irq_disable && rx_head == rx_tail) begin
            irq_armed = 1'b0;
            res.irq_raise = 1'b1;
          end
          rx_store[rx_tail] = item.rx_byte;
          rx_tail = next_ptr(rx_tail);
        end
        default: begin
          if (tx_head != tx_tail) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_store[tx_head];
            tx_head = next_ptr(tx_head);
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one observed result against the oldest prediction.
    task check_result(out_t got);
      out_t exp;
      if (pending_results.size() == 0) begin
        report("result strobe with no pending transaction");
      end else begin
        exp = pending_results.pop_front();
        if (got.read_data !== exp.read_data)
          report($sformatf("read_data exp %h got %h", exp.read_data, got.read_data));
        if (got.tx_valid !== exp.tx_valid)
          report($sformatf("tx_valid exp %b got %b", exp.tx_valid, got.tx_valid));
        if (got.tx_byte !== exp.tx_byte)
          report($sformatf("tx_byte exp %h got %h", exp.tx_byte, got.tx_byte));
        if (got.irq_raise !== exp.irq_raise)
          report($sformatf("irq_raise exp %b got %b", exp.irq_raise, got.irq_raise));
      end
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   in_data   = '0;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  port_scoreboard sb;
  bit             gaps_on = 1'b1;
  int unsigned    idle_cycles = 0;

  serial_port_with_fifos DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Monitor: results are checked and accepted transactions noted at each edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_input(in_data);
    end
  end

  // Watchdog: too many cycles without any transaction or result ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t mk(req_t req, int off, int size, int wb, int rb);
    in_t item;
    item.req_type    = req;
    item.offset      = off[3:0];
    item.access_size = size[3:0];
    item.write_byte  = wb[7:0];
    item.rx_byte     = rb[7:0];
    return item;
  endfunction

  // Random transaction; the profile shifts the mix to fill or empty the FIFOs.
  function automatic in_t random_item(int profile);
    in_t item;
    int  r, w_read, w_write, w_line, off;
    case (profile)
      1:       begin w_read = 15; w_write = 15; w_line = 60; end
      2:       begin w_read = 60; w_write = 10; w_line = 20; end
      3:       begin w_read = 15; w_write = 60; w_line = 10; end
      4:       begin w_read = 20; w_write = 15; w_line = 15; end
      default: begin w_read = 35; w_write = 25; w_line = 25; end
    endcase
    item.offset      = 4'($urandom_range(0, 15));
    item.access_size = 4'($urandom_range(0, 15));
    item.write_byte  = 8'($urandom_range(0, 255));
    item.rx_byte     = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < w_read) begin
      item.req_type = REQ_READ;
      if ($urandom_range(0, 1)) begin
        off = $urandom_range(0, 7);
        item.offset      = 4'(off);
        item.access_size = 4'($urandom_range(8 - off, 8));
      end
    end else if (r < w_read + w_write) begin
      item.req_type = REQ_WRITE;
      if ($urandom_range(0, 9) < 7) begin
        off = $urandom_range(8, 15);
        item.offset      = 4'(off);
        item.access_size = 4'($urandom_range(16 - off, 8));
      end
    end else if (r < w_read + w_write + w_line) begin
      item.req_type = REQ_LINE_RX;
    end else begin
      item.req_type = REQ_DRAIN;
    end
    return item;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send(in_t item);
    int gap;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted result to arrive.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both configuration registers; only called while the block is idle.
  task automatic set_config(logic dis, logic [5:0] num);
    logic [CFG_DATA_W-1:0] dis_word;
    dis_word = CFG_DATA_W'($urandom_range(0, 63));
    dis_word[0] = dis;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IRQ_DISABLE;
    cfg_data  <= dis_word;
    @(posedge clk);
    sb.note_config(CFG_IRQ_DISABLE, dis_word);
    cfg_index <= CFG_IRQ_NUMBER;
    cfg_data  <= num;
    @(posedge clk);
    sb.note_config(CFG_IRQ_NUMBER, num);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(1'b0, 6'd63);

    // Directed part: window edges, every request, interrupt arm and fire.
    send(mk(REQ_READ,     0,  8, 8'h00, 8'h00));  // arms on zero count, pop on empty
    send(mk(REQ_LINE_RX,  0,  1, 8'h00, 8'hFF));  // interrupt fires into empty FIFO
    send(mk(REQ_LINE_RX, 15, 15, 8'hFF, 8'h00));
    send(mk(REQ_READ,     7,  1, 8'h00, 8'h00));
    send(mk(REQ_READ,     4,  4, 8'h00, 8'h00));
    send(mk(REQ_READ,     3,  1, 8'h00, 8'h00));
    send(mk(REQ_READ,     0,  0, 8'h00, 8'h00));  // zero size does nothing
    send(mk(REQ_READ,    15, 15, 8'h00, 8'h00));  // oversize, past the window
    send(mk(REQ_READ,     9,  8, 8'h00, 8'h00));
    send(mk(REQ_WRITE,   15,  1, 8'hA5, 8'h00));
    send(mk(REQ_WRITE,    8,  8, 8'h5A, 8'hFF));
    send(mk(REQ_WRITE,   14,  1, 8'hFF, 8'h00));  // misses the data byte
    send(mk(REQ_WRITE,   15,  0, 8'hFF, 8'h00));
    send(mk(REQ_READ,     8,  8, 8'h00, 8'h00));
    send(mk(REQ_DRAIN,    0,  0, 8'h00, 8'h00));
    send(mk(REQ_DRAIN,   15, 15, 8'hFF, 8'hFF));
    send(mk(REQ_DRAIN,    0,  8, 8'h00, 8'h00));  // drain with empty FIFO
    send(mk(REQ_LINE_RX,  0,  0, 8'h00, 8'h3C));
    send(mk(REQ_READ,     0,  9, 8'h00, 8'h00));
    send(mk(REQ_READ,     0,  4, 8'h00, 8'h00));
    wait_drained();

    // Receive overflow until the dropped-byte count saturates.
    set_config(1'b1, 6'd0);
    repeat (330) send(mk(REQ_LINE_RX, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 255), $urandom_range(0, 255)));
    send(mk(REQ_READ, 0, 4, 8'h00, 8'h00));
    send(mk(REQ_READ, 0, 8, 8'h00, 8'h00));
    wait_drained();

    // Random phases, each under its own configuration.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       set_config(1'b0, 6'd0);
        1:       set_config(1'b1, 6'd63);
        2:       set_config(1'b0, 6'd63);
        3:       set_config(1'b1, 6'd0);
        default: set_config(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      endcase
      gaps_on = (phase != 2);
      repeat (110) send(random_item((phase + $urandom_range(0, 4)) % 5));
      wait_drained();
    end
    gaps_on = 1'b1;

    // Transmit overflow until the write error count saturates, then drain.
    set_config(1'b0, 6'($urandom_range(0, 63)));
    repeat (330) send(mk(REQ_WRITE, 15, $urandom_range(1, 15),
                         $urandom_range(0, 255), $urandom_range(0, 255)));
    send(mk(REQ_READ, 8, 8, 8'h00, 8'h00));
    repeat (70) send(mk(REQ_DRAIN, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 255), $urandom_range(0, 255)));
    wait_drained();

    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/spf_pkg.sv
hdl/spf_ram.sv
hdl/spf_ctrl.sv
hdl/spf_datapath.sv
hdl/serial_port_with_fifos.sv
hdl/spf_checker.sv
tb/tb.sv
